>>> design/kmp_case_insensitive_match_counter_defines.svh
// ----------------------------------------------------------------------------
// KMP match counter assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst_n low.
// ----------------------------------------------------------------------------
`ifndef KMP_CASE_INSENSITIVE_MATCH_COUNTER_DEFINES_SVH
`define KMP_CASE_INSENSITIVE_MATCH_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define KMPCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KMPCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KMPCM_ASSERT_NOW(lbl, ante, cons, msg)
`define KMPCM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> design/kmpcm_pkg.sv
// ----------------------------------------------------------------------------
// kmpcm_pkg
// Shared types, command codes and helpers of the KMP match counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmpcm_pkg;

  // Width of the reported match count field
  localparam int MATCH_COUNT_W = 16;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2
  } cmd_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic       load;   // write sym into the cell at the current length
    logic       step;   // advance partial matches by one text byte
    logic       clr;    // drop all partial matches after this cycle
    logic [7:0] sym;    // folded symbol
  } kmpcm_ctrl_t;

  // Fold ASCII upper case letters to lower case
  function automatic logic [7:0] fold_lc(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

>>> design/kmp_case_insensitive_match_counter.sv
// ----------------------------------------------------------------------------
// kmp_case_insensitive_match_counter
// Case-insensitive pattern occurrence counter built from a row of cells.
// ----------------------------------------------------------------------------
//  channel | dir | tdata            | tuser                          | tlast
//  in_     | in  | symbol[7:0]      | command[1:0]                   | end_of_text
//  out_    | out | match_count[15:0]| match_here[0], pattern_overflow[1] | text_done
//
//  One transfer is taken per cycle unless the output stalls; its result is
//  registered and shown in the cycle after. Each cell compares its stored byte
//  with each text byte and hands its flag on, so one byte per cycle unless stalled.
//  A new transfer is taken while the output register is empty or being read.
//  Reset empties the pattern and the count; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "kmp_case_insensitive_match_counter_defines.svh"

module kmp_case_insensitive_match_counter
  import kmpcm_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] match_count
  output logic [1:0]  out_tuser,  // [0] match_here, [1] pattern_overflow
  output logic        out_tlast
);

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int WIDE_W = (COUNT_BITS > MATCH_COUNT_W) ? COUNT_BITS : MATCH_COUNT_W;
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_PATTERN);

  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt, count_shown;
  logic [WIDE_W-1:0]     count_wide;
  logic [MATCH_COUNT_W-1:0] shown;

  logic        out_valid_r;
  logic [MATCH_COUNT_W-1:0] out_count_r;
  logic        out_hit_r, out_done_r, out_ovf_r;
  logic        hit_nxt, done_nxt, ovf_nxt;

  logic        in_fire;
  logic        full;
  logic        any_hit;
  cmd_t        cmd;
  kmpcm_ctrl_t ctrl;

  logic [MAX_PATTERN:0]   chain;
  logic [MAX_PATTERN-1:0] hit_vec;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign full      = len_r == LEN_FULL;
  assign any_hit   = |hit_vec;

  // Decode the command into cell control and sequencer updates
  always_comb begin
    ctrl.sym  = fold_lc(in_tdata);
    ctrl.load = 1'b0;
    ctrl.step = 1'b0;
    ctrl.clr  = 1'b0;
    len_nxt   = len_r;
    count_nxt = count_r;
    count_shown = count_r;
    hit_nxt   = 1'b0;
    done_nxt  = 1'b0;
    ovf_nxt   = 1'b0;
    if (in_fire) begin
      unique case (cmd)
        CMD_CLEAR: begin
          ctrl.clr    = 1'b1;
          len_nxt     = '0;
          count_nxt   = '0;
          count_shown = '0;
        end
        CMD_APPEND: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            ctrl.load = 1'b1;
            ctrl.clr  = 1'b1;
            len_nxt   = len_r + 1'b1;
          end
        end
        CMD_TEXT: begin
          ctrl.step = 1'b1;
          hit_nxt   = any_hit;
          if (any_hit && count_r != '1) begin
            count_shown = count_r + 1'b1;
          end
          count_nxt = count_shown;
          if (in_tlast) begin
            done_nxt  = 1'b1;
            ctrl.clr  = 1'b1;
            count_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Saturate the count into the reported field
  assign count_wide = WIDE_W'(count_shown);
  assign shown = (count_wide > WIDE_W'({MATCH_COUNT_W{1'b1}})) ?
                 {MATCH_COUNT_W{1'b1}} : count_wide[MATCH_COUNT_W-1:0];

  // Row of pattern cells; the empty prefix always matches
  assign chain[0] = 1'b1;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    kmpcm_cell #(
      .IDX   (g),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .len       (len_r),
      .match_in  (chain[g]),
      .match_out (chain[g+1]),
      .hit       (hit_vec[g])
    );
  end

  // Hold pattern length and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      count_r <= '0;
    end else begin
      len_r   <= len_nxt;
      count_r <= count_nxt;
    end
  end

  // Output register: load on input transfer, drop on output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_count_r <= shown;
      out_hit_r   <= hit_nxt;
      out_done_r  <= done_nxt;
      out_ovf_r   <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = {out_ovf_r, out_hit_r};
  assign out_tlast  = out_done_r;

  `KMPCM_ASSERT_NOW(a_one_last_cell, 1'b1, $onehot0(hit_vec), "more than one cell ends the pattern")
  `KMPCM_ASSERT_NEXT(a_empty_no_hit, in_fire && cmd == CMD_TEXT && len_r == '0, !out_hit_r, "hit with empty pattern")
  `KMPCM_ASSERT_NEXT(a_ovf_only_full, in_fire && cmd == CMD_APPEND && !full, !out_ovf_r, "overflow below capacity")
  `KMPCM_ASSERT_NEXT(a_eot_resets, in_fire && cmd == CMD_TEXT && in_tlast, count_r == '0, "count kept after end of text")
  `KMPCM_ASSERT_NEXT(a_clear_empties, in_fire && cmd == CMD_CLEAR, len_r == '0 && chain[1] == 1'b0, "clear left pattern state")

endmodule

>>> design/kmpcm_cell.sv
// ----------------------------------------------------------------------------
// kmpcm_cell
// One pattern position: holds a pattern byte and the flag that the pattern
// prefix ending here matches the text seen so far; hands the flag onward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmpcm_cell
  import kmpcm_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int LEN_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  kmpcm_ctrl_t      ctrl,
  input  logic [LEN_W-1:0] len,
  input  logic             match_in,
  output logic             match_out,
  output logic             hit
);

  localparam logic [LEN_W-1:0] IDX_L  = LEN_W'(IDX);
  localparam logic [LEN_W-1:0] NEXT_L = LEN_W'(IDX + 1);

  logic [7:0] sym_r;
  logic       match_r;
  logic       match_nxt;
  logic       valid;
  logic       last;
  logic       match_step;

  // Position lies inside the loaded pattern; last position ends it
  assign valid = IDX_L < len;
  assign last  = len == NEXT_L;

  // Prefix up to here matches when the shorter prefix did and this byte agrees
  assign match_step = match_in & valid & (sym_r == ctrl.sym);
  assign hit        = ctrl.step & match_step & last;

  always_comb begin
    match_nxt = match_r;
    if (ctrl.clr) begin
      match_nxt = 1'b0;
    end else if (ctrl.step) begin
      match_nxt = match_step;
    end
  end

  // Hold the pattern byte
  always_ff @(posedge clk) begin
    if (ctrl.load && len == IDX_L) begin
      sym_r <= ctrl.sym;
    end
  end

  // Advance the partial match flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign match_out = match_r;

endmodule

>>> test/kmp_case_insensitive_match_counter_tb.sv
// ----------------------------------------------------------------------------
// kmp_case_insensitive_match_counter_tb
// Drives clear, pattern and text transfers into the KMP match counter, keeps
// its own copy of the pattern, border table, match progress and count, and
// checks every reported byte field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmp_case_insensitive_match_counter_tb
  import kmpcm_pkg::*;
();

  localparam int             PAT_CAP    = 32;
  localparam logic [1:0]     CMD_SPARE  = 2'd3;
  localparam logic [15:0]    COUNT_TOP  = 16'hFFFF;
  localparam int             LONG_HOLD  = 300;
  localparam int             RAND_ITEMS = 1050;

  // One pending input transfer and the gap the sender waits before it
  typedef struct {
    logic [1:0] cmd;
    logic [7:0] sym;
    logic       eot;
    int         gap;
  } byte_cmd_t;

  // One expected per-byte report
  typedef struct {
    logic        hit;
    logic [15:0] count;
    logic        done;
    logic        ovf;
  } match_rpt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] symbol
  logic [1:0]  in_tuser = 2'd0;    // [1:0] command
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [15:0] match_count
  logic [1:0]  out_tuser;          // [0] match_here, [1] pattern_overflow
  logic        out_tlast;

  kmp_case_insensitive_match_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  byte_cmd_t  cmd_fifo[$];
  match_rpt_t awaited_rpts[$];

  // Matcher copy kept by the testbench
  logic [7:0] pat_mem [PAT_CAP];
  logic [5:0] brd_tab [PAT_CAP];
  logic [5:0] pat_len = '0;
  logic [5:0] build_brd = '0;
  logic [5:0] prefix_len = '0;
  logic [15:0] hit_count = '0;

  // Handshake bookkeeping between processes
  int in_taken = 0, drv_seen = 0, rx_taken = 0, rx_seen = 0;
  int hold_tickets = 0, hold_served = 0, hold_left = 0;
  int tx_wait = 0, rx_wait = 0, tx_burst = 0, rx_burst = 0;
  bit drv_busy = 1'b0, tx_fast = 1'b0;
  byte_cmd_t cur_item;

  // Run statistics
  int n_errors = 0, n_queued = 0, n_accepted = 0, n_hits = 0, n_ovf = 0, n_texts = 0;
  logic [15:0] peak_count = '0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_errors < 20) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    end
    n_errors++;
  endtask

  // Idle length for one transfer, with occasional stretches of no idling
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Follow the border chain from a matched prefix over one folded byte
  function automatic logic [5:0] walk_border(input logic [5:0] len, input logic [7:0] c);
    logic [5:0] l;
    logic [5:0] lm1;
    l = len;
    while (l > 0 && pat_mem[l[4:0]] != c) begin
      lm1 = l - 6'd1;
      l = brd_tab[lm1[4:0]];
    end
    if (pat_mem[l[4:0]] == c) begin
      l++;
    end
    return l;
  endfunction

  // Apply one accepted transfer to the matcher copy and queue its report
  task automatic kmp_predict(input logic [1:0] cmd, input logic [7:0] sym, input logic eot);
    logic [7:0] c;
    logic [5:0] q;
    logic [5:0] qm1;
    match_rpt_t r;
    c = (sym >= 8'h41 && sym <= 8'h5A) ? sym + 8'h20 : sym;
    r = '{hit: 1'b0, count: 16'h0, done: 1'b0, ovf: 1'b0};
    n_accepted++;
    if (cmd == CMD_CLEAR) begin
      pat_len = '0;
      build_brd = '0;
      prefix_len = '0;
      hit_count = '0;
    end else if (cmd == CMD_APPEND) begin
      if (pat_len >= PAT_CAP) begin
        r.ovf = 1'b1;
        n_ovf++;
      end else begin
        pat_mem[pat_len[4:0]] = c;
        if (pat_len == 0) begin
          brd_tab[0] = '0;
          build_brd = '0;
        end else begin
          build_brd = walk_border(build_brd, c);
          brd_tab[pat_len[4:0]] = build_brd;
        end
        pat_len++;
        prefix_len = '0;
      end
    end else if (cmd == CMD_TEXT) begin
      if (pat_len > 0) begin
        q = walk_border(prefix_len, c);
        if (q == pat_len) begin
          r.hit = 1'b1;
          n_hits++;
          if (hit_count != COUNT_TOP) begin
            hit_count++;
          end
          qm1 = q - 6'd1;
          q = brd_tab[qm1[4:0]];
        end
        prefix_len = q;
      end
      r.done = eot;
    end
    r.count = hit_count;
    if (hit_count > peak_count) begin
      peak_count = hit_count;
    end
    if (r.done) begin
      n_texts++;
      hit_count = '0;
      prefix_len = '0;
    end
    awaited_rpts = {awaited_rpts, r};
  endtask

  // Check delivered reports first, then record accepted input
  always @(posedge clk) begin
    match_rpt_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        rx_taken++;
        if (awaited_rpts.size() == 0) begin
          report_mismatch("report with nothing awaited, count", int'(out_tdata), 0);
        end else begin
          want = awaited_rpts.pop_front();
          if (out_tuser[0] !== want.hit) begin
            report_mismatch("match_here", int'(out_tuser[0]), int'(want.hit));
          end
          if (out_tdata !== want.count) begin
            report_mismatch("match_count", int'(out_tdata), int'(want.count));
          end
          if (out_tlast !== want.done) begin
            report_mismatch("text_done", int'(out_tlast), int'(want.done));
          end
          if (out_tuser[1] !== want.ovf) begin
            report_mismatch("pattern_overflow", int'(out_tuser[1]), int'(want.ovf));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        in_taken++;
        kmp_predict(in_tuser, in_tdata, in_tlast);
      end
    end
  end

  // Sender: retire the accepted transfer, wait its gap, present the next one
  always @(negedge clk) begin
    logic nxt_valid;
    nxt_valid = in_tvalid;
    if (rst_n) begin
      if (in_tvalid && in_taken != drv_seen) begin
        drv_seen = in_taken;
        nxt_valid = 1'b0;
        drv_busy = 1'b0;
      end
      if (!drv_busy && cmd_fifo.size() > 0) begin
        cur_item = cmd_fifo.pop_front();
        drv_busy = 1'b1;
        tx_wait = cur_item.gap;
      end
      if (drv_busy && !nxt_valid) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else begin
          nxt_valid = 1'b1;
          in_tdata <= cur_item.sym;
          in_tuser <= cur_item.cmd;
          in_tlast <= cur_item.eot;
        end
      end
    end
    in_tvalid <= nxt_valid;
  end

  // Receiver: wait a random gap, possibly none, after each transfer, and hold off long when asked
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_served != hold_tickets) begin
        hold_served = hold_tickets;
        hold_left = LONG_HOLD;
      end
      if (rx_taken != rx_seen) begin
        rx_seen = rx_taken;
        rx_wait = draw_gap(rx_burst);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] sym, input logic eot);
    byte_cmd_t s;
    s.cmd = cmd;
    s.sym = sym;
    s.eot = eot;
    s.gap = tx_fast ? 0 : draw_gap(tx_burst);
    cmd_fifo = {cmd_fifo, s};
    n_queued++;
  endtask

  // Hold the stimulus until every queued transfer is reported
  task automatic wait_drained();
    while (cmd_fifo.size() != 0 || drv_busy || awaited_rpts.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic [7:0] rand_case(input logic [7:0] lc);
    if (lc >= "a" && lc <= "z" && $urandom_range(0, 1) == 1) begin
      return lc - 8'h20;
    end
    return lc;
  endfunction

  function automatic logic [7:0] pick_sym(input logic [7:0] a0, input logic [7:0] a1);
    return rand_case(($urandom_range(0, 1) == 1) ? a1 : a0);
  endfunction

  // One random stretch: noise, or pattern load then a text over a small alphabet
  task automatic gen_sequence();
    int kind, p_len, t_len, k;
    logic [7:0] a0, a1, ch;
    logic drop_end;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 7) begin
      a0 = "a";
      a1 = "b";
    end else begin
      a0 = 8'($urandom_range(0, 255));
      a1 = 8'($urandom_range(0, 255));
    end
    if (kind < 8) begin
      repeat ($urandom_range(1, 5)) begin
        queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      end
    end else begin
      p_len = (kind < 12) ? $urandom_range(28, 36) : $urandom_range(1, 6);
      if (kind < 12 || $urandom_range(0, 4) != 0) begin
        queue_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      for (k = 0; k < p_len; k++) begin
        queue_item(CMD_APPEND, pick_sym(a0, a1), 1'($urandom_range(0, 1)));
      end
      t_len = $urandom_range(1, 40);
      drop_end = ($urandom_range(0, 19) == 0);
      for (k = 0; k < t_len; k++) begin
        ch = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : pick_sym(a0, a1);
        // Break the sequence now and then with a pattern byte mid-text
        if ($urandom_range(0, 49) == 0) begin
          queue_item(CMD_APPEND, pick_sym(a0, a1), 1'b0);
        end
        queue_item(CMD_TEXT, ch, (k == t_len - 1) && !drop_end);
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    int start;
    int k;
    bit pressed;
    pressed = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty pattern, spare command, end marks outside text
    queue_item(CMD_TEXT, "a", 1'b0);
    queue_item(CMD_TEXT, 8'hFF, 1'b1);
    queue_item(CMD_SPARE, 8'h55, 1'b1);
    queue_item(CMD_CLEAR, 8'h00, 1'b1);
    // Pattern "aba" loaded with mixed case; overlapping hits in "aBabA"
    queue_item(CMD_APPEND, "A", 1'b1);
    queue_item(CMD_APPEND, "b", 1'b0);
    queue_item(CMD_APPEND, "A", 1'b0);
    queue_item(CMD_TEXT, "a", 1'b0);
    queue_item(CMD_TEXT, "B", 1'b0);
    queue_item(CMD_TEXT, "a", 1'b0);
    queue_item(CMD_TEXT, "b", 1'b0);
    queue_item(CMD_TEXT, "A", 1'b0);
    // Bytes just outside the letter ranges must not fold
    queue_item(CMD_TEXT, 8'h40, 1'b0);
    queue_item(CMD_TEXT, 8'h5B, 1'b0);
    queue_item(CMD_TEXT, 8'h60, 1'b0);
    queue_item(CMD_TEXT, 8'h7B, 1'b1);
    queue_item(CMD_SPARE, 8'hAA, 1'b0);
    // Extend after text with a zero byte
    queue_item(CMD_APPEND, 8'h00, 1'b0);
    queue_item(CMD_TEXT, "a", 1'b0);
    queue_item(CMD_TEXT, "B", 1'b0);
    queue_item(CMD_TEXT, "a", 1'b0);
    queue_item(CMD_TEXT, 8'h00, 1'b1);
    queue_item(CMD_CLEAR, 8'hFF, 1'b0);
    queue_item(CMD_APPEND, "Z", 1'b0);
    queue_item(CMD_TEXT, "z", 1'b0);
    queue_item(CMD_TEXT, "Z", 1'b1);
    wait_drained();

    // Random stretches, with one long receiver hold-off midway
    start = n_queued;
    while (n_queued - start < RAND_ITEMS) begin
      if (!pressed && n_queued - start > RAND_ITEMS / 2) begin
        pressed = 1'b1;
        wait_drained();
        hold_tickets++;
        tx_fast = 1'b1;
        queue_item(CMD_CLEAR, 8'h00, 1'b0);
        queue_item(CMD_APPEND, "a", 1'b0);
        for (k = 0; k < 40; k++) begin
          queue_item(CMD_TEXT, pick_sym("a", "b"), k == 39);
        end
        tx_fast = 1'b0;
        wait_drained();
      end
      gen_sequence();
    end
    wait_drained();

    // Let any stray report show up
    repeat (10) @(posedge clk);

    $display("covered %0d transfers: %0d texts ended, %0d matches, %0d dropped pattern bytes",
             n_accepted, n_texts, n_hits, n_ovf);
    $display("peak count %0d, one long receiver hold-off with the input stalled", peak_count);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/kmpcm_pkg.sv
design/kmpcm_cell.sv
design/kmp_case_insensitive_match_counter.sv
test/kmp_case_insensitive_match_counter_tb.sv
